FILE: hdl/stl_pkg.sv
package stl_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_INT,
        MODE_FRAC,
        MODE_STR,
        MODE_OPER,
        MODE_ERR
    } mode_t;

    typedef enum logic [3:0] {
        KIND_KEYWORD,
        KIND_IDENT,
        KIND_NUMBER,
        KIND_STRING,
        KIND_COMMA,
        KIND_SEMI,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_OPERATOR,
        KIND_END
    } kind_t;

    // operator ids
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_EQ   = 4'd1;
    localparam logic [3:0] OP_GT   = 4'd2;
    localparam logic [3:0] OP_LT   = 4'd3;
    localparam logic [3:0] OP_BANG = 4'd4;
    localparam logic [3:0] OP_ADD  = 4'd5;
    localparam logic [3:0] OP_SUB  = 4'd6;
    localparam logic [3:0] OP_MUL  = 4'd7;
    localparam logic [3:0] OP_DIV  = 4'd8;
    localparam logic [3:0] OP_GE   = 4'd9;
    localparam logic [3:0] OP_LE   = 4'd10;
    localparam logic [3:0] OP_NE   = 4'd11;
    localparam logic [3:0] OP_LTGT = 4'd12;

    // error codes
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

    localparam logic [3:0] KW_NONE = 4'd0;
    localparam int         NUM_KW  = 10;
    localparam logic [9:0] ALL_KW  = 10'h3FF;
    localparam logic [7:0] CH_QUOTE = 8'h27;

    localparam logic [7:0] KW_TEXT [NUM_KW][6] = '{
        '{"S", "E", "L", "E", "C", "T"},
        '{"F", "R", "O", "M", 8'h00, 8'h00},
        '{"W", "H", "E", "R", "E", 8'h00},
        '{"I", "N", "S", "E", "R", "T"},
        '{"U", "P", "D", "A", "T", "E"},
        '{"D", "E", "L", "E", "T", "E"},
        '{"A", "N", "D", 8'h00, 8'h00, 8'h00},
        '{"I", "S", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"N", "O", "T", 8'h00, 8'h00, 8'h00},
        '{"O", "R", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd6, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd3, 3'd2, 3'd3, 3'd2
    };

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  keyword_id;
        logic [3:0]  operator_id;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [1:0]  error_code;
        logic        last_of_run;
    } res_t;

    function automatic res_t make_res(kind_t kind, logic [3:0] kw, logic [3:0] op,
                                      logic [15:0] start, logic [15:0] len,
                                      logic [1:0] err);
        res_t r;
        r.kind         = kind;
        r.keyword_id   = kw;
        r.operator_id  = op;
        r.start_offset = start;
        r.token_length = len;
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    // drop keywords whose character at idx differs from c
    function automatic logic [9:0] filter_kw(logic [9:0] mask, logic idx_ok,
                                             logic [2:0] idx, logic [7:0] c);
        logic [9:0] m;
        m = mask;
        for (int k = 0; k < NUM_KW; k++) begin
            if (!(idx_ok && (idx < KW_LEN[k]) && (KW_TEXT[k][idx] == c)))
                m[k] = 1'b0;
        end
        return m;
    endfunction

    function automatic logic [3:0] op_code(logic [7:0] c);
        logic [3:0] op;
        case (c)
            "=":     op = OP_EQ;
            ">":     op = OP_GT;
            "<":     op = OP_LT;
            "!":     op = OP_BANG;
            "+":     op = OP_ADD;
            "-":     op = OP_SUB;
            "*":     op = OP_MUL;
            "/":     op = OP_DIV;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

FILE: hdl/sql_token_lexer.sv
// SQL token lexer: takes query text one byte per transfer on the s_ side and
// gives tokens (kind, keyword id, operator id, start offset, length, error code)
// on the m_ side. An input transfer with s_tuser[0] low carries no byte; s_tlast
// ends the query, flushes any open token, adds an end token and restarts offsets
// at zero. One byte is taken per clock while no results are held or the last
// held one is leaving; each input transfer yields zero to three tokens, which
// sit in a three-entry result register and leave one per clock while m_tready
// is high. Words, numbers, strings and the first character of a two-character
// operator are held in the scan state until the next byte or the end of the
// query decides them. An unexpected byte gives one error token and everything
// up to the end of the query is then dropped, with no end token; the same holds
// for a string still open at the end. Offsets saturate at 2^POS_BITS-1
// internally and at 65535 on the port.
module sql_token_lexer
    import stl_pkg::*;
#(
    parameter int POS_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [0:0]  s_tuser,   // [0] has_char
    input  logic        s_tlast,   // final_item

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [3:0] keyword_id, [7:4] operator_id,
                                   // [23:8] start_offset, [39:24] token_length,
                                   // [41:40] error_code, [47:42] zero
    output logic [3:0]  m_tuser,   // [3:0] kind
    output logic        m_tlast    // last_of_run
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    function automatic logic [15:0] clip16(logic [POS_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [POS_BITS-1:0] span(logic [POS_BITS-1:0] from,
                                                 logic [POS_BITS-1:0] to);
        return (to >= from) ? to - from : '0;
    endfunction

    // word token: keyword when a surviving candidate has exactly this length
    function automatic res_t word_res(logic [POS_BITS-1:0] start,
                                      logic [POS_BITS-1:0] len, logic [9:0] cand);
        logic [3:0] id;
        id = KW_NONE;
        for (int k = 0; k < NUM_KW; k++) begin
            if (cand[k] && (32'(len) == 32'(KW_LEN[k])))
                id = 4'(k + 1);
        end
        return make_res((id != KW_NONE) ? KIND_KEYWORD : KIND_IDENT, id, OP_NONE,
                        clip16(start), clip16(len), ERR_NONE);
    endfunction

    // scan state
    mode_t               mode_reg, mode_next, mode_mid;
    logic [POS_BITS-1:0] pos_reg, pos_next, pos_mid;
    logic [POS_BITS-1:0] tb_reg, tb_next, tb_mid;
    logic [9:0]          cand_reg, cand_next, cand_mid;
    logic [3:0]          pend_reg, pend_next, pend_mid;

    // result register
    res_t       res_reg [3];
    logic       bvalid_reg;
    logic [1:0] cnt_reg;
    logic [1:0] idx_reg;

    res_t       res_now [3];
    logic [1:0] n_now;

    logic [7:0] c;
    logic       has_char, fin, s_accept, m_accept, out_done;
    logic       is_alpha, is_digit, is_space, is_word;
    logic [3:0] opc, pair_op;
    logic       used, ends;
    logic [POS_BITS-1:0] span_p, pos_inc;
    logic       idx_ok;

    assign c        = s_tdata;
    assign has_char = s_tuser[0];
    assign fin      = s_tlast;

    assign is_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    assign is_digit = (c >= "0") && (c <= "9");
    assign is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    assign is_word  = is_alpha || is_digit || (c == "_");
    assign opc      = op_code(c);

    assign span_p  = span(tb_reg, pos_reg);
    assign pos_inc = sat_inc(pos_reg);
    assign idx_ok  = 32'(span_p) < 32'd6;

    // two-character operators
    always_comb begin
        if      (pend_reg == OP_GT   && c == "=") pair_op = OP_GE;
        else if (pend_reg == OP_LT   && c == "=") pair_op = OP_LE;
        else if (pend_reg == OP_BANG && c == "=") pair_op = OP_NE;
        else if (pend_reg == OP_LT   && c == ">") pair_op = OP_LTGT;
        else                                      pair_op = OP_NONE;
    end

    // used: byte belongs to the open token; ends: open token is emitted now
    always_comb begin
        used = 1'b0;
        ends = 1'b0;
        if (has_char) begin
            unique case (mode_reg) inside
                MODE_WORD: begin
                    used = is_word;
                    ends = !is_word;
                end
                MODE_INT, MODE_FRAC: begin
                    used = is_digit || (c == "." && mode_reg == MODE_INT);
                    ends = !used;
                end
                MODE_STR: begin
                    used = 1'b1;
                    ends = (c == CH_QUOTE);
                end
                MODE_OPER: begin
                    used = (pair_op != OP_NONE);
                    ends = 1'b1;
                end
                MODE_IDLE: begin
                    used = 1'b0;
                end
                default: begin
                    used = 1'b1;   // error mode swallows bytes
                end
            endcase
        end
    end

    // scan state after the byte, then after the end of query
    always_comb begin
        mode_mid = mode_reg;
        pos_mid  = pos_reg;
        tb_mid   = tb_reg;
        cand_mid = cand_reg;
        pend_mid = pend_reg;
        if (has_char) begin
            unique case (mode_reg) inside
                MODE_WORD: begin
                    if (used) cand_mid = filter_kw(cand_reg, idx_ok, span_p[2:0], c);
                    else      mode_mid = MODE_IDLE;
                end
                MODE_INT, MODE_FRAC: begin
                    if (!used)             mode_mid = MODE_IDLE;
                    else if (c == ".")     mode_mid = MODE_FRAC;
                end
                MODE_STR: begin
                    if (ends) mode_mid = MODE_IDLE;
                end
                MODE_OPER: begin
                    pend_mid = OP_NONE;
                    mode_mid = MODE_IDLE;
                end
                default: ;
            endcase
            if (!used) begin
                if (is_space) begin
                    // skipped
                end else if (is_alpha || c == "_") begin
                    mode_mid = MODE_WORD;
                    tb_mid   = pos_reg;
                    cand_mid = filter_kw(ALL_KW, 1'b1, 3'd0, c);
                end else if (is_digit) begin
                    mode_mid = MODE_INT;
                    tb_mid   = pos_reg;
                end else if (c == CH_QUOTE) begin
                    mode_mid = MODE_STR;
                    tb_mid   = pos_inc;
                end else if (c == "," || c == ";" || c == "(" || c == ")") begin
                    // single-byte punctuation, no state
                end else if (opc == OP_GT || opc == OP_LT || opc == OP_BANG) begin
                    mode_mid = MODE_OPER;
                    pend_mid = opc;
                    tb_mid   = pos_reg;
                end else if (opc != OP_NONE) begin
                    // single operator, no state
                end else begin
                    mode_mid = MODE_ERR;
                end
            end
            pos_mid = pos_inc;
        end
    end

    always_comb begin
        if (fin) begin
            mode_next = MODE_IDLE;
            pos_next  = '0;
            tb_next   = '0;
            cand_next = ALL_KW;
            pend_next = OP_NONE;
        end else begin
            mode_next = mode_mid;
            pos_next  = pos_mid;
            tb_next   = tb_mid;
            cand_next = cand_mid;
            pend_next = pend_mid;
        end
    end

    // results of this transfer, in order
    always_comb begin
        logic end_tok;
        n_now   = 2'd0;
        end_tok = 1'b1;
        for (int i = 0; i < 3; i++)
            res_now[i] = make_res(KIND_END, KW_NONE, OP_NONE, 16'd0, 16'd0, ERR_NONE);

        if (has_char) begin
            if (ends) begin
                unique case (mode_reg) inside
                    MODE_WORD: res_now[n_now] = word_res(tb_reg, span_p, cand_reg);
                    MODE_INT, MODE_FRAC:
                        res_now[n_now] = make_res(KIND_NUMBER, KW_NONE, OP_NONE,
                                                  clip16(tb_reg), clip16(span_p), ERR_NONE);
                    MODE_STR:
                        res_now[n_now] = make_res(KIND_STRING, KW_NONE, OP_NONE,
                                                  clip16(tb_reg), clip16(span_p), ERR_NONE);
                    default:
                        res_now[n_now] = make_res(KIND_OPERATOR, KW_NONE,
                                                  (pair_op != OP_NONE) ? pair_op : pend_reg,
                                                  clip16(tb_reg),
                                                  (pair_op != OP_NONE) ? 16'd2 : 16'd1,
                                                  ERR_NONE);
                endcase
                n_now = n_now + 2'd1;
            end
            if (!used) begin
                if (c == ",") begin
                    res_now[n_now] = make_res(KIND_COMMA, KW_NONE, OP_NONE,
                                              clip16(pos_reg), 16'd1, ERR_NONE);
                    n_now = n_now + 2'd1;
                end else if (c == ";") begin
                    res_now[n_now] = make_res(KIND_SEMI, KW_NONE, OP_NONE,
                                              clip16(pos_reg), 16'd1, ERR_NONE);
                    n_now = n_now + 2'd1;
                end else if (c == "(") begin
                    res_now[n_now] = make_res(KIND_LPAREN, KW_NONE, OP_NONE,
                                              clip16(pos_reg), 16'd1, ERR_NONE);
                    n_now = n_now + 2'd1;
                end else if (c == ")") begin
                    res_now[n_now] = make_res(KIND_RPAREN, KW_NONE, OP_NONE,
                                              clip16(pos_reg), 16'd1, ERR_NONE);
                    n_now = n_now + 2'd1;
                end else if (is_space || is_word || c == CH_QUOTE
                             || opc == OP_GT || opc == OP_LT || opc == OP_BANG) begin
                    // starts or skips, nothing emitted
                end else if (opc != OP_NONE) begin
                    res_now[n_now] = make_res(KIND_OPERATOR, KW_NONE, opc,
                                              clip16(pos_reg), 16'd1, ERR_NONE);
                    n_now = n_now + 2'd1;
                end else begin
                    res_now[n_now] = make_res(KIND_END, KW_NONE, OP_NONE,
                                              clip16(pos_reg), 16'd0, ERR_UNEXPECTED);
                    n_now = n_now + 2'd1;
                end
            end
        end

        if (fin) begin
            unique case (mode_mid) inside
                MODE_WORD: begin
                    res_now[n_now] = word_res(tb_mid, span(tb_mid, pos_mid), cand_mid);
                    n_now = n_now + 2'd1;
                end
                MODE_INT, MODE_FRAC: begin
                    res_now[n_now] = make_res(KIND_NUMBER, KW_NONE, OP_NONE, clip16(tb_mid),
                                              clip16(span(tb_mid, pos_mid)), ERR_NONE);
                    n_now = n_now + 2'd1;
                end
                MODE_STR: begin
                    res_now[n_now] = make_res(KIND_END, KW_NONE, OP_NONE, clip16(tb_mid),
                                              16'd0, ERR_UNTERMINATED);
                    n_now   = n_now + 2'd1;
                    end_tok = 1'b0;
                end
                MODE_OPER: begin
                    res_now[n_now] = make_res(KIND_OPERATOR, KW_NONE, pend_mid,
                                              clip16(tb_mid), 16'd1, ERR_NONE);
                    n_now = n_now + 2'd1;
                end
                MODE_IDLE: ;
                default: end_tok = 1'b0;
            endcase
            if (end_tok) begin
                res_now[n_now] = make_res(KIND_END, KW_NONE, OP_NONE, clip16(pos_mid),
                                          16'd0, ERR_NONE);
                n_now = n_now + 2'd1;
            end
        end

        if (n_now != 2'd0)
            res_now[n_now - 2'd1].last_of_run = 1'b1;
    end

    // handshakes: input waits only while the held results are not all gone
    assign out_done = m_tready && (idx_reg == cnt_reg - 2'd1);
    assign s_tready = !bvalid_reg || out_done;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            tb_reg     <= '0;
            cand_reg   <= ALL_KW;
            pend_reg   <= OP_NONE;
            bvalid_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            idx_reg    <= 2'd0;
        end else begin
            if (s_accept) begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                tb_reg   <= tb_next;
                cand_reg <= cand_next;
                pend_reg <= pend_next;
            end
            if (s_accept && n_now != 2'd0) begin
                bvalid_reg <= 1'b1;
                cnt_reg    <= n_now;
                idx_reg    <= 2'd0;
            end else if (m_accept) begin
                if (idx_reg == cnt_reg - 2'd1) bvalid_reg <= 1'b0;
                else                           idx_reg    <= idx_reg + 2'd1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept && n_now != 2'd0) begin
            for (int i = 0; i < 3; i++)
                res_reg[i] <= res_now[i];
        end
    end

    res_t cur;
    assign cur = res_reg[idx_reg];

    assign m_tvalid = bvalid_reg;
    assign m_tdata  = {6'd0, cur.error_code, cur.token_length, cur.start_offset,
                       cur.operator_id, cur.keyword_id};
    assign m_tuser  = cur.kind;
    assign m_tlast  = cur.last_of_run;

endmodule

FILE: hdl/stl_checker.sv
module stl_checker
    import stl_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // nothing is offered right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an error token is an end kind with zero length and closes its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[41:40] != ERR_NONE |->
            m_tuser == KIND_END && m_tdata[39:24] == 16'd0 && m_tlast)
        else $error("malformed error token");

    // keyword ids only on keyword tokens, never with an operator id
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] != KW_NONE |->
            m_tuser == KIND_KEYWORD && m_tdata[7:4] == OP_NONE)
        else $error("keyword id on wrong token");

    // the input side is open whenever no result is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty result register");

endmodule

bind sql_token_lexer stl_checker u_stl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
